// ----- hw/rtl/slrs_pkg.sv -----
// Package for the subgroup lane reduce/scan unit: commands, modes, states, helpers.
`timescale 1ns / 1ps
`default_nettype none
package slrs_pkg;

  localparam int unsigned LANES_DEF = 16;
  localparam logic [3:0] SHUF_MASK = 4'hF;

  localparam logic [4:0] CMD_ELECT      = 5'd0;
  localparam logic [4:0] CMD_ALL        = 5'd1;
  localparam logic [4:0] CMD_ANY        = 5'd2;
  localparam logic [4:0] CMD_ALLEQ      = 5'd3;
  localparam logic [4:0] CMD_BCAST      = 5'd4;
  localparam logic [4:0] CMD_BCASTFIRST = 5'd5;
  localparam logic [4:0] CMD_BALLOT     = 5'd6;
  localparam logic [4:0] CMD_INVBALLOT  = 5'd7;
  localparam logic [4:0] CMD_SHUF       = 5'd8;
  localparam logic [4:0] CMD_SHUFXOR    = 5'd9;
  localparam logic [4:0] CMD_SHUFUP     = 5'd10;
  localparam logic [4:0] CMD_SHUFDOWN   = 5'd11;
  localparam logic [4:0] CMD_IADD       = 5'd12;
  localparam logic [4:0] CMD_IMUL       = 5'd13;
  localparam logic [4:0] CMD_SMIN       = 5'd14;
  localparam logic [4:0] CMD_UMIN       = 5'd15;
  localparam logic [4:0] CMD_SMAX       = 5'd16;
  localparam logic [4:0] CMD_UMAX       = 5'd17;
  localparam logic [4:0] CMD_AND        = 5'd18;
  localparam logic [4:0] CMD_OR         = 5'd19;
  localparam logic [4:0] CMD_XOR        = 5'd20;
  localparam logic [4:0] CMD_LAND       = 5'd21;
  localparam logic [4:0] CMD_LOR        = 5'd22;
  localparam logic [4:0] CMD_LXOR       = 5'd23;

  localparam logic [1:0] MODE_REDUCE = 2'd0;
  localparam logic [1:0] MODE_INCL   = 2'd1;
  localparam logic [1:0] MODE_EXCL   = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD, ST_PASS, ST_RD, ST_EMIT, ST_WAIT
  } slrs_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // write the incoming lane
    logic pass_clr;   // restart the accumulation pass
    logic pass_step;  // fold the current lane, advance the index
    logic rd_issue;   // issue the read for the current emit lane
    logic out_load;   // capture the result into the output register
    logic out_clr;    // result taken
  } slrs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic load_last;  // the lane being loaded is the final one
    logic pass_last;  // the pass index is at the final lane
    logic emit_last;  // the emit index is at the final lane
    logic out_full;   // output register holds a result
  } slrs_sts_t;

  function automatic logic [31:0] red_identity(input logic [4:0] op);
    logic [31:0] r;
    unique case (op)
      CMD_IMUL:           r = 32'd1;
      CMD_SMIN:           r = 32'h7FFF_FFFF;
      CMD_UMIN:           r = '1;
      CMD_SMAX:           r = 32'h8000_0000;
      CMD_AND, CMD_LAND:  r = '1;
      default:            r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/slrs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module slrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/slrs_ctrl.sv -----
// Controller state machine: load, accumulation pass, emit sequence.
`timescale 1ns / 1ps
`default_nettype none
module slrs_ctrl import slrs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  output      logic      out_valid,
  input  wire logic      out_stall,
  input  wire slrs_sts_t sts,
  output      slrs_cmd_t cmd
);
  slrs_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_valid && sts.load_last) state_nxt = ST_PASS;
      ST_PASS: if (sts.pass_last) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (!out_stall) begin
          state_nxt = sts.emit_last ? ST_LOAD : ST_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        cmd.pass_clr = in_valid && sts.load_last;
      end
      ST_PASS: cmd.pass_step = 1'b1;
      ST_RD:   cmd.rd_issue = 1'b1;
      ST_EMIT: cmd.out_load = 1'b1;
      ST_WAIT: begin
        out_valid   = 1'b1;
        cmd.out_clr = !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

  // Output valid follows the full flag of the datapath register
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sts.out_full) else $error("valid without result");
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open during emit");
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS && sts.pass_last) |=> state_r == ST_RD)
    else $error("pass did not end");
endmodule
`default_nettype wire

// ----- hw/rtl/slrs_dp.sv -----
// Datapath: lane stores, masks, accumulation pass and per-lane result logic.
`timescale 1ns / 1ps
`default_nettype none
module slrs_dp import slrs_pkg::*; #(
  parameter int unsigned LANES = LANES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire slrs_cmd_t   cmd,
  output      slrs_sts_t   sts,
  input  wire logic [4:0]  in_cmd,
  input  wire logic [1:0]  in_scan_mode,
  input  wire logic        in_lane_active,
  input  wire logic        in_lane_pred,
  input  wire logic [31:0] in_lane_value,
  input  wire logic [31:0] in_lane_param,
  output      logic [3:0]  out_lane_index,
  output      logic [31:0] out_lane_result,
  output      logic        out_last_lane
);
  localparam int unsigned IW = $clog2(LANES);
  localparam logic [IW-1:0] LAST = IW'(LANES - 1);

  logic [IW-1:0]    load_idx_r, pass_idx_r, emit_idx_r;
  logic [IW-1:0]    load_idx_nxt, pass_idx_nxt, emit_idx_nxt;
  logic [LANES-1:0] act_r, pred_r, act_nxt, pred_nxt;
  logic [4:0]       gcmd_r, gcmd_nxt;
  logic [1:0]       gmode_r, gmode_nxt;
  logic [31:0]      acc_r, acc_nxt, first_val_r, first_val_nxt, bcast_id_r, bcast_id_nxt;
  logic             found_r, found_nxt, eq_r, eq_nxt;
  logic [IW-1:0]    first_r, first_nxt;
  logic [31:0]      post_r, post_nxt;
  logic             out_full_r, out_full_nxt;
  logic [31:0]      res_r, res_nxt;
  logic [IW-1:0]    oidx_r, oidx_nxt;
  logic             olast_r, olast_nxt;

  // RAM ports
  logic [IW-1:0] val_raddr, prm_raddr, src_raddr;
  logic [31:0]   val_rdata, prm_rdata, src_rdata;
  logic [31:0]   src_full;
  logic          src_ok_r, src_ok_nxt;

  // Pass-through of lane-0 fields during load
  wire lane0 = (load_idx_r == '0);

  slrs_ram #(.WIDTH(32), .DEPTH(LANES)) u_val (
    .clk, .wr_en(cmd.load), .wr_addr(load_idx_r), .wr_data(in_lane_value),
    .rd_addr(val_raddr), .rd_data(val_rdata));
  slrs_ram #(.WIDTH(32), .DEPTH(LANES)) u_prm (
    .clk, .wr_en(cmd.load), .wr_addr(load_idx_r), .wr_data(in_lane_param),
    .rd_addr(prm_raddr), .rd_data(prm_rdata));
  // Copy of the value store for the shuffle source read
  slrs_ram #(.WIDTH(32), .DEPTH(LANES)) u_src (
    .clk, .wr_en(cmd.load), .wr_addr(load_idx_r), .wr_data(in_lane_value),
    .rd_addr(src_raddr), .rd_data(src_rdata));

  // Pass reads lanes in order; emit reads the emit lane
  assign val_raddr = cmd.rd_issue ? emit_idx_r : pass_idx_nxt;
  // Address the param store with the next emit index so the lane's param is ready at read issue
  assign prm_raddr = emit_idx_nxt;

  // Shuffle source address for the emit lane
  always_comb begin
    src_full = 32'(emit_idx_r);
    unique case (gcmd_r)
      CMD_BCAST:   src_full = bcast_id_r;
      CMD_SHUF:    src_full = {28'd0, prm_rdata[3:0] & SHUF_MASK};
      CMD_SHUFXOR: src_full = {28'd0, (4'(emit_idx_r) ^ prm_rdata[3:0]) & SHUF_MASK};
      CMD_SHUFUP:  src_full = 32'(emit_idx_r) - prm_rdata;
      CMD_SHUFDOWN: src_full = 32'(emit_idx_r) + prm_rdata;
      default:     src_full = 32'(emit_idx_r);
    endcase
  end
  assign src_raddr  = src_full[IW-1:0];
  assign src_ok_nxt = cmd.rd_issue ? (src_full < 32'(LANES)) : src_ok_r;

  // Load: masks, command, counter
  always_comb begin
    load_idx_nxt = load_idx_r;
    act_nxt = act_r;
    pred_nxt = pred_r;
    gcmd_nxt = gcmd_r;
    gmode_nxt = gmode_r;
    bcast_id_nxt = bcast_id_r;
    if (cmd.load) begin
      if (lane0) begin
        gcmd_nxt = in_cmd;
        gmode_nxt = in_scan_mode;
        bcast_id_nxt = in_lane_param;
        act_nxt = '0;
        pred_nxt = '0;
      end
      act_nxt[load_idx_r]  = in_lane_active;
      pred_nxt[load_idx_r] = in_lane_pred;
      load_idx_nxt = (load_idx_r == LAST) ? '0 : load_idx_r + 1'b1;
    end
  end

  // Accumulation pass: one lane a cycle from the value RAM
  logic [31:0] v, comb;
  logic        on;
  always_comb begin
    v  = val_rdata;
    on = act_r[pass_idx_r];
    unique case (gcmd_r)
      CMD_IMUL: comb = acc_r * v;
      CMD_SMIN: comb = ($signed(v) < $signed(acc_r)) ? v : acc_r;
      CMD_UMIN: comb = (v < acc_r) ? v : acc_r;
      CMD_SMAX: comb = ($signed(v) > $signed(acc_r)) ? v : acc_r;
      CMD_UMAX: comb = (v > acc_r) ? v : acc_r;
      CMD_AND, CMD_LAND: comb = acc_r & v;
      CMD_OR, CMD_LOR:   comb = acc_r | v;
      CMD_XOR, CMD_LXOR: comb = acc_r ^ v;
      default: comb = acc_r + v;
    endcase
  end

  always_comb begin
    pass_idx_nxt = pass_idx_r;
    acc_nxt = acc_r;
    found_nxt = found_r;
    first_nxt = first_r;
    first_val_nxt = first_val_r;
    eq_nxt = eq_r;
    if (cmd.pass_clr) begin
      pass_idx_nxt = '0;
      acc_nxt = red_identity(gcmd_nxt);
      found_nxt = 1'b0;
      first_nxt = '0;
      first_val_nxt = '0;
      eq_nxt = 1'b1;
    end else if (cmd.pass_step) begin
      if (on) begin
        acc_nxt = comb;
        if (!found_r) begin
          found_nxt = 1'b1;
          first_nxt = pass_idx_r;
          first_val_nxt = v;
        end else if (v != first_val_r) begin
          eq_nxt = 1'b0;
        end
      end
      pass_idx_nxt = (pass_idx_r == LAST) ? '0 : pass_idx_r + 1'b1;
    end
  end

  // Emit: rerun the scan from the per-lane values, one lane a step
  logic [31:0] ecomb;
  always_comb begin
    unique case (gcmd_r)
      CMD_IMUL: ecomb = post_r * val_rdata;
      CMD_SMIN: ecomb = ($signed(val_rdata) < $signed(post_r)) ? val_rdata : post_r;
      CMD_UMIN: ecomb = (val_rdata < post_r) ? val_rdata : post_r;
      CMD_SMAX: ecomb = ($signed(val_rdata) > $signed(post_r)) ? val_rdata : post_r;
      CMD_UMAX: ecomb = (val_rdata > post_r) ? val_rdata : post_r;
      CMD_AND, CMD_LAND: ecomb = post_r & val_rdata;
      CMD_OR, CMD_LOR:   ecomb = post_r | val_rdata;
      CMD_XOR, CMD_LXOR: ecomb = post_r ^ val_rdata;
      default: ecomb = post_r + val_rdata;
    endcase
  end

  logic ballot_any, ballot_all;
  logic [31:0] ballot;
  always_comb begin
    ballot = '0;
    ballot[LANES-1:0] = act_r & pred_r;
    ballot_any = |(act_r & pred_r);
    ballot_all = &(~act_r | pred_r);
  end

  always_comb begin
    emit_idx_nxt = emit_idx_r;
    post_nxt = post_r;
    res_nxt = res_r;
    oidx_nxt = oidx_r;
    olast_nxt = olast_r;
    out_full_nxt = out_full_r;
    if (cmd.pass_clr) begin
      emit_idx_nxt = '0;
      post_nxt = red_identity(gcmd_nxt);
    end
    if (cmd.out_load) begin
      post_nxt = act_r[emit_idx_r] ? ecomb : post_r;
      unique case (gcmd_r)
        CMD_ELECT:      res_nxt = {31'd0, found_r && (first_r == emit_idx_r)};
        CMD_ALL:        res_nxt = {31'd0, ballot_all};
        CMD_ANY:        res_nxt = {31'd0, ballot_any};
        CMD_ALLEQ:      res_nxt = {31'd0, eq_r};
        CMD_BCASTFIRST: res_nxt = found_r ? first_val_r : '0;
        CMD_BALLOT:     res_nxt = ballot;
        CMD_INVBALLOT:  res_nxt = {31'd0, val_rdata[emit_idx_r]};
        CMD_BCAST, CMD_SHUF, CMD_SHUFXOR, CMD_SHUFUP, CMD_SHUFDOWN:
          res_nxt = src_ok_r ? src_rdata : '0;
        default: begin
          if (gmode_r == MODE_INCL)      res_nxt = act_r[emit_idx_r] ? ecomb : post_r;
          else if (gmode_r == MODE_EXCL) res_nxt = post_r;
          else                           res_nxt = acc_r;
        end
      endcase
      oidx_nxt = emit_idx_r;
      olast_nxt = (emit_idx_r == LAST);
      out_full_nxt = 1'b1;
    end
    if (cmd.out_clr) begin
      out_full_nxt = 1'b0;
      emit_idx_nxt = (emit_idx_r == LAST) ? '0 : emit_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r <= '0; pass_idx_r <= '0; emit_idx_r <= '0;
      act_r <= '0; pred_r <= '0; gcmd_r <= '0; gmode_r <= '0;
      acc_r <= '0; out_full_r <= 1'b0; found_r <= 1'b0; eq_r <= 1'b1;
      first_r <= '0;
    end else begin
      load_idx_r <= load_idx_nxt; pass_idx_r <= pass_idx_nxt;
      emit_idx_r <= emit_idx_nxt; act_r <= act_nxt; pred_r <= pred_nxt;
      gcmd_r <= gcmd_nxt; gmode_r <= gmode_nxt; acc_r <= acc_nxt;
      out_full_r <= out_full_nxt; found_r <= found_nxt; eq_r <= eq_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_val_r <= first_val_nxt; bcast_id_r <= bcast_id_nxt;
    post_r <= post_nxt; res_r <= res_nxt;
    oidx_r <= oidx_nxt; olast_r <= olast_nxt; src_ok_r <= src_ok_nxt;
  end

  assign sts.load_last = (load_idx_r == LAST);
  assign sts.pass_last = (pass_idx_r == LAST);
  assign sts.emit_last = (emit_idx_r == LAST);
  assign sts.out_full  = out_full_r;

  assign out_lane_index  = 4'(oidx_r);
  assign out_lane_result = res_r;
  assign out_last_lane   = olast_r;

  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !out_full_r) else $error("load while result pending");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_clr && olast_r) |=> emit_idx_r == '0) else $error("emit wrap");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.pass_step)) else $error("load during pass");
endmodule
`default_nettype wire

// ----- hw/rtl/subgroup_lane_reduce_scan_unit.sv -----
// Top level of the subgroup lane reduce/scan unit.
// Loads one lane per transaction, then runs one accumulation pass over the
// value store (one RAM read a lane), then emits one result per lane in lane
// order, each through a RAM read, the result register and a handshake that
// waits while out_stall is high. A new group is taken only once the last
// lane of the group before it has been handed over.
`timescale 1ns / 1ps
`default_nettype none
module subgroup_lane_reduce_scan_unit import slrs_pkg::*; #(
  parameter int unsigned LANES = LANES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [4:0]  in_cmd,
  input  wire logic [1:0]  in_scan_mode,
  input  wire logic        in_lane_active,
  input  wire logic        in_lane_pred,
  input  wire logic [31:0] in_lane_value,
  input  wire logic [31:0] in_lane_param,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [3:0]  out_lane_index,
  output      logic [31:0] out_lane_result,
  output      logic        out_last_lane
);
  slrs_cmd_t cmd;
  slrs_sts_t sts;

  slrs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd);

  slrs_dp #(.LANES(LANES)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_cmd, .in_scan_mode, .in_lane_active,
    .in_lane_pred, .in_lane_value, .in_lane_param, .out_lane_index,
    .out_lane_result, .out_last_lane);
endmodule
`default_nettype wire

// ----- dv/slrs_checker.sv -----
// Result predictor and scoreboard for the subgroup lane reduce/scan unit.
`timescale 1ns / 1ps
module slrs_checker import slrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  in_cmd,
  input  logic [1:0]  in_scan_mode,
  input  logic        in_lane_active,
  input  logic        in_lane_pred,
  input  logic [31:0] in_lane_value,
  input  logic [31:0] in_lane_param,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_lane_index,
  input  logic [31:0] out_lane_result,
  input  logic        out_last_lane,
  output int          fail_count,
  output int          pending
);
  localparam int NL = 16;

  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] res;
    logic        last;
  } lane_res_t;

  lane_res_t   lane_results_q[$];
  logic [31:0] vals[NL];
  logic [31:0] params[NL];
  logic [NL-1:0] act_bits, prd_bits;
  logic [4:0]  grp_cmd;
  logic [1:0]  grp_mode;
  int          lane_cnt;

  assign pending = lane_results_q.size();

  function automatic logic [31:0] fetch_lane(logic [31:0] src);
    return (src < NL) ? vals[src] : 32'd0;
  endfunction

  function automatic logic [31:0] fold(logic [4:0] op, logic [31:0] a, logic [31:0] v);
    case (op)
      CMD_IMUL: return a * v;
      CMD_SMIN: return ($signed(v) < $signed(a)) ? v : a;
      CMD_UMIN: return (v < a) ? v : a;
      CMD_SMAX: return ($signed(v) > $signed(a)) ? v : a;
      CMD_UMAX: return (v > a) ? v : a;
      CMD_AND, CMD_LAND: return a & v;
      CMD_OR, CMD_LOR: return a | v;
      CMD_XOR, CMD_LXOR: return a ^ v;
      default: return a + v;
    endcase
  endfunction

  // Work out the results of a complete group and queue them
  task automatic predict_group();
    int first;
    bit any_act;
    logic [31:0] all_p, any_p, eq, ballot, acc, prior, r;
    logic [31:0] res[NL];
    first = 0; any_act = 0;
    for (int i = NL - 1; i >= 0; i--) if (act_bits[i]) begin first = i; any_act = 1; end
    if (grp_cmd <= CMD_SHUFDOWN) begin
      all_p = 1; any_p = 0; eq = 1; ballot = 0;
      for (int i = 0; i < NL; i++) if (act_bits[i]) begin
        if (!prd_bits[i]) all_p = 0;
        else begin any_p = 1; ballot[i] = 1'b1; end
        if (vals[i] != vals[first]) eq = 0;
      end
      for (int i = 0; i < NL; i++) begin
        case (grp_cmd)
          CMD_ELECT:      r = (any_act && i == first) ? 32'd1 : 32'd0;
          CMD_ALL:        r = all_p;
          CMD_ANY:        r = any_p;
          CMD_ALLEQ:      r = eq;
          CMD_BCAST:      r = fetch_lane(params[0]);
          CMD_BCASTFIRST: r = any_act ? vals[first] : 32'd0;
          CMD_BALLOT:     r = ballot;
          CMD_INVBALLOT:  r = {31'd0, vals[i][i]};
          CMD_SHUF:       r = fetch_lane({28'd0, params[i][3:0]});
          CMD_SHUFXOR:    r = fetch_lane({28'd0, 4'(i) ^ params[i][3:0]});
          CMD_SHUFUP:     r = fetch_lane(32'(i) - params[i]);
          default:        r = fetch_lane(32'(i) + params[i]);
        endcase
        res[i] = r;
      end
    end else begin
      acc = red_identity(grp_cmd);
      if (grp_cmd > CMD_LXOR) acc = 0;
      for (int i = 0; i < NL; i++) begin
        prior = acc;
        if (act_bits[i]) acc = fold(grp_cmd, acc, vals[i]);
        res[i] = (grp_mode == MODE_EXCL) ? prior : acc;
      end
      if (grp_mode != MODE_INCL && grp_mode != MODE_EXCL)
        for (int i = 0; i < NL; i++) res[i] = acc;
    end
    for (int i = 0; i < NL; i++) lane_results_q.push_back('{4'(i), res[i], i == NL - 1});
  endtask

  // Watch both channels, predict on input, compare on output
  always @(posedge clk) begin
    lane_res_t exp_r;
    if (!rst_n) begin
      lane_cnt <= 0;
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (lane_cnt == 0) begin
          grp_cmd = in_cmd; grp_mode = in_scan_mode; act_bits = 0; prd_bits = 0;
        end
        act_bits[lane_cnt] = in_lane_active;
        prd_bits[lane_cnt] = in_lane_pred;
        vals[lane_cnt] = in_lane_value;
        params[lane_cnt] = in_lane_param;
        if (lane_cnt == NL - 1) begin
          predict_group();
          lane_cnt <= 0;
        end else lane_cnt <= lane_cnt + 1;
      end
      if (out_valid && !out_stall) begin
        if (lane_results_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected transaction idx=%0d res=%h",
                                        out_lane_index, out_lane_result);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = lane_results_q.pop_front();
          if (exp_r != {out_lane_index, out_lane_result, out_last_lane}) begin
            if (fail_count < 10)
              $display("ERROR: exp idx=%0d res=%h last=%b got idx=%0d res=%h last=%b",
                       exp_r.idx, exp_r.res, exp_r.last,
                       out_lane_index, out_lane_result, out_last_lane);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- dv/tb_top.sv -----
// Stimulus, clocking and verdict for the subgroup lane reduce/scan unit.
`timescale 1ns / 1ps
module tb_top;
  import slrs_pkg::*;
  localparam int NL = 16;
  localparam int WATCHDOG = 20000;
  localparam logic [4:0] CMD_SPARE  = 5'd31;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [4:0] in_cmd = 0;
  logic [1:0] in_scan_mode = 0;
  logic in_lane_active = 0, in_lane_pred = 0;
  logic [31:0] in_lane_value = 0, in_lane_param = 0;
  logic [3:0] out_lane_index;
  logic [31:0] out_lane_result;
  logic out_last_lane;
  int fail_count, pending, idle_cycles;
  bit quiet, hold_off;

  always #4 clk = ~clk;

  subgroup_lane_reduce_scan_unit dut (.*);
  slrs_checker chk (.*);

  // Receiver stall: random bursts, one long hold-off, none at the tail
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        out_stall <= 0;
        hold_off = 0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        n = $urandom_range(18, 1);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end else @(posedge clk);
    end
  end

  // Watchdog on accepted transactions
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one lane and hold it until accepted
  task automatic send_lane(logic [4:0] c, logic [1:0] m, logic a, logic p,
                           logic [31:0] v, logic [31:0] q);
    if (!quiet && $urandom_range(4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    in_valid <= 1; in_cmd <= c; in_scan_mode <= m;
    in_lane_active <= a; in_lane_pred <= p; in_lane_value <= v; in_lane_param <= q;
    @(posedge clk iff !in_stall);
  endtask

  function automatic logic [31:0] rand_word(int kind);
    case (kind)
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(40);
      5: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // One subgroup; style 0 all active, 1 none active, else random mask
  task automatic send_group(logic [4:0] c, logic [1:0] m, int style);
    logic [31:0] base;
    logic a;
    int vk, pk;
    base = rand_word($urandom_range(6));
    vk = $urandom_range(7);
    pk = $urandom_range(7);
    for (int i = 0; i < NL; i++) begin
      a = (style == 0) ? 1'b1 : (style == 1) ? 1'b0 : 1'($urandom);
      send_lane(i == 0 ? c : 5'($urandom), i == 0 ? m : 2'($urandom), a, 1'($urandom),
                (vk == 7) ? base : rand_word(vk), rand_word(pk));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Every command once but IADD, an unused command and mode, empty and
    // full masks; hold off the receiver midway and drop idling at the tail
    for (int g = 0; g < 24; g++) begin
      if (g == 16) hold_off = 1;
      if (g == 21) quiet = 1;
      send_group((g == 12) ? CMD_SPARE : 5'(g), (g == 13) ? MODE_SPARE : 2'(g % 3),
                 g % 3);
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
